>>> rtl/assert_macros.svh
// Assertion macros for the one-wire bus master RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Check sampled on the rising clock edge, switched off during reset
`define OW_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Check sampled on the rising clock edge, also active during reset
`define OW_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define OW_ASSERT(label, prop, msg)
`define OW_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

>>> rtl/ow_pkg.sv
// Shared types and constants for the one-wire bus master.
// No dependencies; imported by every module of the block.
`default_nettype none

package ow_pkg;

   // Timing register file
   localparam int NUM_CFG     = 8;
   localparam int CFG_WIDTH   = 10;
   localparam int CFG_INDEX_W = 3;

   typedef enum logic [CFG_INDEX_W-1:0] {
      CFG_RESET_LOW   = 3'd0,
      CFG_PRES_DELAY  = 3'd1,
      CFG_PRES_WINDOW = 3'd2,
      CFG_RESET_TAIL  = 3'd3,
      CFG_START_LOW   = 3'd4,
      CFG_WRITE_HOLD  = 3'd5,
      CFG_READ_SAMPLE = 3'd6,
      CFG_SLOT_REC    = 3'd7
   } cfg_index_type;

   typedef logic [NUM_CFG-1:0][CFG_WIDTH-1:0] cfg_regs_type;

   localparam logic [CFG_WIDTH-1:0] RST_RESET_LOW   = 10'd480;
   localparam logic [CFG_WIDTH-1:0] RST_PRES_DELAY  = 10'd15;
   localparam logic [CFG_WIDTH-1:0] RST_PRES_WINDOW = 10'd60;
   localparam logic [CFG_WIDTH-1:0] RST_RESET_TAIL  = 10'd410;
   localparam logic [CFG_WIDTH-1:0] RST_START_LOW   = 10'd2;
   localparam logic [CFG_WIDTH-1:0] RST_WRITE_HOLD  = 10'd60;
   localparam logic [CFG_WIDTH-1:0] RST_READ_SAMPLE = 10'd1;
   localparam logic [CFG_WIDTH-1:0] RST_SLOT_REC    = 10'd50;

   // Byte framing, LSB first
   localparam int          BITS_PER_BYTE = 8;
   localparam logic [2:0]  LAST_BIT      = 3'(BITS_PER_BYTE - 1);

   // Request kinds
   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_RESET = 2'd1,
      OP_WRITE = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   // Bus phases
   typedef enum logic [3:0] {
      PH_IDLE   = 4'd0,
      PH_RLOW   = 4'd1,
      PH_PDELAY = 4'd2,
      PH_PPOLL  = 4'd3,
      PH_RTAIL  = 4'd4,
      PH_WSTART = 4'd5,
      PH_WHOLD  = 4'd6,
      PH_WREC   = 4'd7,
      PH_RSTART = 4'd8,
      PH_RWAIT  = 4'd9,
      PH_RREC   = 4'd10
   } phase_type;

   // Classified request held in the queue
   typedef struct packed {
      op_type     op;
      logic       is_cmd;
      logic [7:0] tx_byte;
      logic       bus_level;
   } item_type;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_CNT_W = 2;

endpackage

`default_nettype wire

>>> rtl/ow_ifs.sv
// Valid/ready channel interfaces for requests and responses.
// Standalone; used by the front, back and top-level modules.
`default_nettype none

interface ow_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] tx_byte;
   logic       bus_level;

   modport source (output valid, output kind, output tx_byte, output bus_level,
                   input ready);
   modport sink   (input valid, input kind, input tx_byte, input bus_level,
                   output ready);
endinterface

interface ow_rsp_if;
   logic       valid;
   logic       ready;
   logic       drive_low;
   logic       busy_res;
   logic       done_res;
   logic [7:0] rx_byte;
   logic       presence_seen;
   logic       rejected;

   modport source (output valid, output drive_low, output busy_res, output done_res,
                   output rx_byte, output presence_seen, output rejected,
                   input ready);
   modport sink   (input valid, input drive_low, input busy_res, input done_res,
                   input rx_byte, input presence_seen, input rejected,
                   output ready);
endinterface

`default_nettype wire

>>> rtl/ow_front.sv
// Front end: accepts requests and classifies them into queue items.
// Depends on ow_pkg and ow_req_if.
`default_nettype none

module ow_front import ow_pkg::*; (
   ow_req_if.sink    req_chan,
   output logic      push_valid,
   input  logic      push_ready,
   output item_type  push_item
);

   // Request handshake passes straight to the queue
   assign push_valid     = req_chan.valid;
   assign req_chan.ready = push_ready;

   // Classify: write commands keep their byte, ticks keep the line level
   always_comb begin
      push_item           = '0;
      push_item.op        = op_type'(req_chan.kind);
      push_item.is_cmd    = 1'b0;
      push_item.tx_byte   = '0;
      push_item.bus_level = 1'b0;
      case (push_item.op)
         OP_TICK: begin
            push_item.bus_level = req_chan.bus_level;
         end
         OP_WRITE: begin
            push_item.is_cmd  = 1'b1;
            push_item.tx_byte = req_chan.tx_byte;
         end
         OP_RESET, OP_READ: begin
            push_item.is_cmd = 1'b1;
         end
         default: begin
            push_item.is_cmd = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> rtl/ow_queue.sv
// Short FIFO between the front and back ends.
// Depends on ow_pkg.
`default_nettype none

module ow_queue import ow_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  item_type push_item,
   output logic     pop_valid,
   input  logic     pop_ready,
   output item_type pop_item
);

   item_type                 slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                     do_push, do_pop;

   assign push_ready = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and fill-level update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

>>> rtl/ow_back.sv
// Back end: timing registers, bus phase sequencer and response register.
// Depends on ow_pkg, ow_rsp_if and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ow_back import ow_pkg::*; #(
   parameter int COUNT_WIDTH = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CFG_INDEX_W-1:0] csr_index,
   input  logic [CFG_WIDTH-1:0]   csr_wdata,
   input  logic                   pop_valid,
   output logic                   pop_ready,
   input  item_type               pop_item,
   ow_rsp_if.source               rsp_chan
);

   localparam int LW = (COUNT_WIDTH > CFG_WIDTH + 1) ? COUNT_WIDTH : CFG_WIDTH + 1;
   localparam logic [LW-1:0] LEN_MAX = LW'((1 << COUNT_WIDTH) - 1);

   typedef struct packed {
      phase_type  phase;
      logic [2:0] bit_idx;
      logic [7:0] shift;
      logic [7:0] rbyte;
      logic       done;
   } ctx_type;

   typedef struct packed {
      logic       drive_low;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic       presence_seen;
      logic       rejected;
   } rsp_type;

   cfg_regs_type           cfg_ff;
   phase_type              phase_ff;
   logic [COUNT_WIDTH-1:0] tick_ff, tick_in;
   logic [2:0]             bit_ff;
   logic [7:0]             shift_ff;
   logic [7:0]             rbyte_ff;
   logic                   pres_ff, pres_in;
   logic                   out_valid_ff, out_valid_in;
   rsp_type                out_ff, out_in;
   ctx_type                cur, nx;
   logic                   fire;
   logic [COUNT_WIDTH-1:0] cur_len;
   logic [COUNT_WIDTH:0]   tick_p1;

   function automatic logic [CFG_WIDTH-1:0] at_least_one(input logic [CFG_WIDTH-1:0] v);
      return (v == '0) ? CFG_WIDTH'(1) : v;
   endfunction

   // Length of a phase in ticks, saturated to the counter range
   function automatic logic [COUNT_WIDTH-1:0] len_of(input phase_type p,
                                                     input cfg_regs_type c);
      logic [LW-1:0] raw;
      raw = LW'(1);
      case (p)
         PH_RLOW:            raw = LW'(at_least_one(c[CFG_RESET_LOW]));
         PH_PDELAY:          raw = LW'(c[CFG_PRES_DELAY]);
         PH_PPOLL:           raw = LW'(at_least_one(c[CFG_PRES_WINDOW]));
         PH_RTAIL:           raw = LW'(c[CFG_RESET_TAIL]);
         PH_WSTART, PH_RSTART: raw = LW'(at_least_one(c[CFG_START_LOW]));
         PH_WHOLD:           raw = LW'(at_least_one(c[CFG_WRITE_HOLD]));
         PH_RWAIT:           raw = LW'(c[CFG_READ_SAMPLE]) + LW'(1);
         PH_WREC, PH_RREC:   raw = LW'(c[CFG_SLOT_REC]);
         default:            raw = LW'(1);
      endcase
      if (raw > LEN_MAX) begin
         raw = LEN_MAX;
      end
      return raw[COUNT_WIDTH-1:0];
   endfunction

   // Phase successor, with end-of-bit and end-of-byte bookkeeping
   function automatic ctx_type advance(input ctx_type s);
      ctx_type r;
      r = s;
      case (s.phase)
         PH_RLOW:   r.phase = PH_PDELAY;
         PH_PDELAY: r.phase = PH_PPOLL;
         PH_PPOLL:  r.phase = PH_RTAIL;
         PH_RTAIL: begin
            r.phase = PH_IDLE;
            r.done  = 1'b1;
         end
         PH_WSTART: r.phase = PH_WHOLD;
         PH_WHOLD:  r.phase = PH_WREC;
         PH_WREC: begin
            r.shift = s.shift >> 1;
            if (s.bit_idx == LAST_BIT) begin
               r.bit_idx = '0;
               r.phase   = PH_IDLE;
               r.done    = 1'b1;
            end else begin
               r.bit_idx = s.bit_idx + 3'd1;
               r.phase   = PH_WSTART;
            end
         end
         PH_RSTART: r.phase = PH_RWAIT;
         PH_RWAIT:  r.phase = PH_RREC;
         PH_RREC: begin
            if (s.bit_idx == LAST_BIT) begin
               r.rbyte   = s.shift;
               r.bit_idx = '0;
               r.phase   = PH_IDLE;
               r.done    = 1'b1;
            end else begin
               r.bit_idx = s.bit_idx + 3'd1;
               r.phase   = PH_RSTART;
            end
         end
         default: r.phase = PH_IDLE;
      endcase
      return r;
   endfunction

   // Take the queue head whenever the response register is free or draining
   assign fire      = pop_valid && (!out_valid_ff || rsp_chan.ready);
   assign pop_ready = !out_valid_ff || rsp_chan.ready;

   assign cur_len = len_of(phase_ff, cfg_ff);
   assign tick_p1 = {1'b0, tick_ff} + (COUNT_WIDTH + 1)'(1);

   // One request: command start or rejection, or one tick of the current phase
   always_comb begin
      cur.phase   = phase_ff;
      cur.bit_idx = bit_ff;
      cur.shift   = shift_ff;
      cur.rbyte   = rbyte_ff;
      cur.done    = 1'b0;
      nx          = cur;
      tick_in     = tick_ff;
      pres_in     = pres_ff;
      out_in      = '0;

      if (pop_item.is_cmd) begin
         if (phase_ff != PH_IDLE) begin
            out_in.rejected = 1'b1;
         end else begin
            tick_in    = '0;
            nx.bit_idx = '0;
            case (pop_item.op)
               OP_RESET: begin
                  pres_in  = 1'b0;
                  nx.phase = PH_RLOW;
               end
               OP_WRITE: begin
                  nx.shift = pop_item.tx_byte;
                  nx.phase = PH_WSTART;
               end
               OP_READ: begin
                  nx.shift = '0;
                  nx.phase = PH_RSTART;
               end
               default: begin
                  nx.phase = PH_IDLE;
               end
            endcase
         end
      end else if (phase_ff != PH_IDLE) begin
         if (phase_ff == PH_PPOLL && !pop_item.bus_level) begin
            pres_in = 1'b1;
         end
         // Read sample on the last tick of the wait phase
         if (phase_ff == PH_RWAIT && tick_p1 >= {1'b0, cur_len}) begin
            nx.shift = {pop_item.bus_level, shift_ff[7:1]};
         end
         tick_in = tick_p1[COUNT_WIDTH-1:0];
         if (tick_p1 >= {1'b0, cur_len}) begin
            nx      = advance(nx);
            tick_in = '0;
            // At most one zero-length phase follows any phase
            if (nx.phase != PH_IDLE && len_of(nx.phase, cfg_ff) == '0) begin
               nx = advance(nx);
            end
         end
      end

      // Line drive for the coming tick
      case (nx.phase)
         PH_RLOW, PH_WSTART, PH_RSTART: out_in.drive_low = 1'b1;
         PH_WHOLD:                      out_in.drive_low = !nx.shift[0];
         default:                       out_in.drive_low = 1'b0;
      endcase
      out_in.busy_res      = (nx.phase != PH_IDLE);
      out_in.done_res      = nx.done;
      out_in.rx_byte       = nx.rbyte;
      out_in.presence_seen = pres_in;
   end

   assign out_valid_in = fire || (out_valid_ff && !rsp_chan.ready);

   // Timing registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff[CFG_RESET_LOW]   <= RST_RESET_LOW;
         cfg_ff[CFG_PRES_DELAY]  <= RST_PRES_DELAY;
         cfg_ff[CFG_PRES_WINDOW] <= RST_PRES_WINDOW;
         cfg_ff[CFG_RESET_TAIL]  <= RST_RESET_TAIL;
         cfg_ff[CFG_START_LOW]   <= RST_START_LOW;
         cfg_ff[CFG_WRITE_HOLD]  <= RST_WRITE_HOLD;
         cfg_ff[CFG_READ_SAMPLE] <= RST_READ_SAMPLE;
         cfg_ff[CFG_SLOT_REC]    <= RST_SLOT_REC;
      end else if (csr_we) begin
         cfg_ff[csr_index] <= csr_wdata;
      end
   end

   // Sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         tick_ff      <= '0;
         bit_ff       <= '0;
         shift_ff     <= '0;
         rbyte_ff     <= '0;
         pres_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (fire) begin
            phase_ff <= nx.phase;
            tick_ff  <= tick_in;
            bit_ff   <= nx.bit_idx;
            shift_ff <= nx.shift;
            rbyte_ff <= nx.rbyte;
            pres_ff  <= pres_in;
         end
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      if (fire) begin
         out_ff <= out_in;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.drive_low     = out_ff.drive_low;
   assign rsp_chan.busy_res      = out_ff.busy_res;
   assign rsp_chan.done_res      = out_ff.done_res;
   assign rsp_chan.rx_byte       = out_ff.rx_byte;
   assign rsp_chan.presence_seen = out_ff.presence_seen;
   assign rsp_chan.rejected      = out_ff.rejected;

   `OW_ASSERT(a_done_not_busy, out_valid_ff && out_ff.done_res |-> !out_ff.busy_res, "done with busy set")
   `OW_ASSERT(a_reject_busy, out_valid_ff && out_ff.rejected |-> out_ff.busy_res, "rejected while idle")
   `OW_ASSERT(a_drive_busy, out_valid_ff && out_ff.drive_low |-> out_ff.busy_res, "line driven while idle")
   `OW_ASSERT_ALWAYS(a_idle_bit0, phase_ff == PH_IDLE |-> bit_ff == '0, "bit index not cleared")

endmodule

`default_nettype wire

>>> rtl/one_wire_bus_master_unit.sv
// One-wire bus master: each request (tick or command) yields one response.
// Throughput: one request per cycle unless the response side stalls;
// the phase sequencer updates once per request. A request passes through the queue
// and then the response register; a two-entry queue lets both sides stall apart.
// Reset: synchronous, active high; phase idle, counters and flags cleared,
// timing registers loaded with their default tick counts.
`default_nettype none

module one_wire_bus_master_unit import ow_pkg::*; #(
   parameter int COUNT_WIDTH = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   ow_req_if.sink                 req_chan,
   ow_rsp_if.source               rsp_chan,
   input  logic                   csr_we,
   input  logic [CFG_INDEX_W-1:0] csr_index,
   input  logic [CFG_WIDTH-1:0]   csr_wdata
);

   logic     push_valid, push_ready;
   logic     pop_valid, pop_ready;
   item_type push_item, pop_item;

   ow_front u_front (
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   ow_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   ow_back #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_item  (pop_item),
      .rsp_chan  (rsp_chan)
   );

endmodule

`default_nettype wire
